// ----- rtl/cfta_pkg.sv -----
package cfta_pkg;

    localparam int DIR_W = 16;
    localparam int MAG_W = 16;
    localparam int SUM_W = 17;
    localparam int DIV_W = 17;
    localparam int FACE_W = 3;
    localparam int TEXEL_W = 12;
    localparam int FS_W = 13;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 4;

    localparam int MAX_FACE_SIZE_DEF = 4096;
    localparam logic [FS_W-1:0] FACE_SIZE_RESET = 13'd256;

    // register index as seen on paddr[2]
    localparam logic REG_FACE_SIZE = 1'b0;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic [FACE_W-1:0] face;
        logic              degenerate;
    } tag_t;

endpackage

// ----- rtl/cfta_front.sv -----
module cfta_front #(
    parameter int MAX_FACE_SIZE = cfta_pkg::MAX_FACE_SIZE_DEF,
    parameter int QW = $clog2(MAX_FACE_SIZE),
    parameter int NW = cfta_pkg::SUM_W + QW
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [cfta_pkg::DIR_W-1:0] dir_x,
    input  logic signed [cfta_pkg::DIR_W-1:0] dir_y,
    input  logic signed [cfta_pkg::DIR_W-1:0] dir_z,
    input  logic [cfta_pkg::FS_W-1:0]         face_size,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [NW-1:0]                     out_num_u,
    output logic [NW-1:0]                     out_num_v,
    output logic [cfta_pkg::DIV_W-1:0]        out_div,
    output cfta_pkg::tag_t                    out_tag
);

    localparam int CW = (cfta_pkg::FS_W > $clog2(MAX_FACE_SIZE + 1)) ?
                        cfta_pkg::FS_W : $clog2(MAX_FACE_SIZE + 1);

    logic [cfta_pkg::SUM_W-1:0] xe, ye, ze;
    logic [cfta_pkg::MAG_W-1:0] ax, ay, az, m;
    logic [cfta_pkg::SUM_W-1:0] u, v;
    cfta_pkg::axis_t            axis;
    logic                       neg;
    cfta_pkg::tag_t             tag;

    logic                       va_reg;
    logic [cfta_pkg::SUM_W-1:0] a_u_reg, a_v_reg;
    logic [cfta_pkg::MAG_W-1:0] m_reg;
    cfta_pkg::tag_t             tag_a_reg;
    logic                       ready_a;

    logic                       vb_reg;
    logic [NW-1:0]              num_u_reg, num_v_reg;
    logic [cfta_pkg::DIV_W-1:0] div_reg;
    cfta_pkg::tag_t             tag_b_reg;
    logic                       ready_b;

    logic [CW-1:0]              fs_ext, s_clamp;
    logic [QW-1:0]              s_m1;

    // sign-extended components, magnitudes
    assign xe = {dir_x[cfta_pkg::DIR_W-1], dir_x};
    assign ye = {dir_y[cfta_pkg::DIR_W-1], dir_y};
    assign ze = {dir_z[cfta_pkg::DIR_W-1], dir_z};
    assign ax = dir_x[cfta_pkg::DIR_W-1] ? cfta_pkg::MAG_W'(-xe) : cfta_pkg::MAG_W'(xe);
    assign ay = dir_y[cfta_pkg::DIR_W-1] ? cfta_pkg::MAG_W'(-ye) : cfta_pkg::MAG_W'(ye);
    assign az = dir_z[cfta_pkg::DIR_W-1] ? cfta_pkg::MAG_W'(-ze) : cfta_pkg::MAG_W'(ze);

    // major axis, ties to the lower axis, and per-face u and v
    always_comb
    begin
        priority if (ax >= ay && ax >= az)
        begin
            axis = cfta_pkg::AXIS_X;
            m    = ax;
            neg  = dir_x[cfta_pkg::DIR_W-1];
            u    = neg ? ze : -ze;
            v    = -ye;
        end
        else if (ay >= az)
        begin
            axis = cfta_pkg::AXIS_Y;
            m    = ay;
            neg  = dir_y[cfta_pkg::DIR_W-1];
            u    = xe;
            v    = neg ? -ze : ze;
        end
        else
        begin
            axis = cfta_pkg::AXIS_Z;
            m    = az;
            neg  = dir_z[cfta_pkg::DIR_W-1];
            u    = neg ? -xe : xe;
            v    = -ye;
        end
        tag.face       = {axis, neg};
        tag.degenerate = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
    end

    assign ready_a  = !va_reg || ready_b;
    assign ready_b  = !vb_reg || out_ready;
    assign in_ready = ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                va_reg <= in_valid;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    // c + |m| lies in 0..2|m|, so the sum fits without a sign
    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            a_u_reg   <= u + {1'b0, m};
            a_v_reg   <= v + {1'b0, m};
            m_reg     <= m;
            tag_a_reg <= tag;
        end
    end

    // effective face size, clamped to 1..MAX_FACE_SIZE
    always_comb
    begin
        fs_ext = CW'(face_size);
        priority if (fs_ext == '0)
        begin
            s_clamp = CW'(1);
        end
        else if (fs_ext > CW'(MAX_FACE_SIZE))
        begin
            s_clamp = CW'(MAX_FACE_SIZE);
        end
        else
        begin
            s_clamp = fs_ext;
        end
        s_m1 = QW'(s_clamp - CW'(1));
    end

    always_ff @(posedge clk)
    begin
        if (ready_b && va_reg)
        begin
            num_u_reg <= NW'(a_u_reg) * NW'(s_m1);
            num_v_reg <= NW'(a_v_reg) * NW'(s_m1);
            div_reg   <= {m_reg, 1'b0};
            tag_b_reg <= tag_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_num_u = num_u_reg;
    assign out_num_v = num_v_reg;
    assign out_div   = div_reg;
    assign out_tag   = tag_b_reg;

endmodule

// ----- rtl/cfta_div_cell.sv -----
module cfta_div_cell #(
    parameter int QW = 12,
    parameter int NW = 29,
    parameter int K = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [NW-1:0]              in_rem_u,
    input  logic [NW-1:0]              in_rem_v,
    input  logic [QW-1:0]              in_q_u,
    input  logic [QW-1:0]              in_q_v,
    input  logic [cfta_pkg::DIV_W-1:0] in_div,
    input  cfta_pkg::tag_t             in_tag,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [NW-1:0]              out_rem_u,
    output logic [NW-1:0]              out_rem_v,
    output logic [QW-1:0]              out_q_u,
    output logic [QW-1:0]              out_q_v,
    output logic [cfta_pkg::DIV_W-1:0] out_div,
    output cfta_pkg::tag_t             out_tag
);

    logic [NW-1:0]              shifted;
    logic                       ge_u, ge_v;
    logic [NW-1:0]              rem_u_next, rem_v_next;
    logic [QW-1:0]              q_u_next, q_v_next;

    logic                       valid_reg;
    logic [NW-1:0]              rem_u_reg, rem_v_reg;
    logic [QW-1:0]              q_u_reg, q_v_reg;
    logic [cfta_pkg::DIV_W-1:0] div_reg;
    cfta_pkg::tag_t             tag_reg;

    // one restoring step: quotient bit K for both lanes
    always_comb
    begin
        shifted    = NW'(in_div) << K;
        ge_u       = in_rem_u >= shifted;
        ge_v       = in_rem_v >= shifted;
        rem_u_next = ge_u ? in_rem_u - shifted : in_rem_u;
        rem_v_next = ge_v ? in_rem_v - shifted : in_rem_v;
        q_u_next    = in_q_u;
        q_v_next    = in_q_v;
        q_u_next[K] = ge_u;
        q_v_next[K] = ge_v;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_u_reg <= rem_u_next;
            rem_v_reg <= rem_v_next;
            q_u_reg   <= q_u_next;
            q_v_reg   <= q_v_next;
            div_reg   <= in_div;
            tag_reg   <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem_u = rem_u_reg;
    assign out_rem_v = rem_v_reg;
    assign out_q_u   = q_u_reg;
    assign out_q_v   = q_v_reg;
    assign out_div   = div_reg;
    assign out_tag   = tag_reg;

endmodule

// ----- rtl/cube_face_texel_address.sv -----
// cube map face selection and texel addressing
//
// input stream: one direction per transfer, three signed q1.14 components
// output stream: face and degenerate flag on tuser, texel column and row on tdata
// apb port: one register, face_size at byte address 0, read back on prdata;
//   write it only while the pipeline is empty
//
// latency is QW + 2 cycles from input transfer to output valid, QW being
// clog2(MAX_FACE_SIZE): one cycle for axis selection, one for the multiply
// by face_size - 1, then one cycle per quotient bit in the chain of divider
// cells (14 cycles at the default size of 4096)
// throughput is one transfer per cycle; every stage holds one item
//
// reset clears every valid bit and sets face_size to 256
// when the receiver stalls, each stage keeps its item and empty stages still
// fill, so the input keeps taking transfers until the whole chain is full
module cube_face_texel_address #(
    parameter int MAX_FACE_SIZE = cfta_pkg::MAX_FACE_SIZE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cfta_pkg::APB_AW-1:0]        paddr,
    input  logic [cfta_pkg::APB_DW-1:0]        pwdata,
    output logic [cfta_pkg::APB_DW-1:0]        prdata,
    output logic                               pready,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [cfta_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // dir_x, dir_y, dir_z
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [cfta_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // texel_x, texel_y
    output logic [cfta_pkg::OUT_USER_W-1:0]    m_axis_tuser   // face, degenerate
);

    localparam int QW = $clog2(MAX_FACE_SIZE);
    localparam int NW = cfta_pkg::SUM_W + QW;

    logic [cfta_pkg::FS_W-1:0]  face_size_reg;

    logic                       c_valid [0:QW];
    logic                       c_ready [0:QW];
    logic [NW-1:0]              c_rem_u [0:QW];
    logic [NW-1:0]              c_rem_v [0:QW];
    logic [QW-1:0]              c_q_u   [0:QW];
    logic [QW-1:0]              c_q_v   [0:QW];
    logic [cfta_pkg::DIV_W-1:0] c_div   [0:QW];
    cfta_pkg::tag_t             c_tag   [0:QW];

    cfta_pkg::tag_t             tag_out;
    logic [cfta_pkg::TEXEL_W-1:0] texel_x, texel_y;

    // configuration
    assign pready = 1'b1;
    assign prdata = cfta_pkg::APB_DW'(face_size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_size_reg <= cfta_pkg::FACE_SIZE_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == cfta_pkg::REG_FACE_SIZE)
        begin
            face_size_reg <= pwdata[cfta_pkg::FS_W-1:0];
        end
    end

    cfta_front #(
        .MAX_FACE_SIZE (MAX_FACE_SIZE),
        .QW            (QW),
        .NW            (NW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .dir_x     (s_axis_tdata[15:0]),
        .dir_y     (s_axis_tdata[31:16]),
        .dir_z     (s_axis_tdata[47:32]),
        .face_size (face_size_reg),
        .out_valid (c_valid[0]),
        .out_ready (c_ready[0]),
        .out_num_u (c_rem_u[0]),
        .out_num_v (c_rem_v[0]),
        .out_div   (c_div[0]),
        .out_tag   (c_tag[0])
    );

    assign c_q_u[0] = '0;
    assign c_q_v[0] = '0;

    // divider chain, most significant quotient bit first
    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        cfta_div_cell #(
            .QW (QW),
            .NW (NW),
            .K  (QW - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .in_rem_u  (c_rem_u[i]),
            .in_rem_v  (c_rem_v[i]),
            .in_q_u    (c_q_u[i]),
            .in_q_v    (c_q_v[i]),
            .in_div    (c_div[i]),
            .in_tag    (c_tag[i]),
            .out_valid (c_valid[i+1]),
            .out_ready (c_ready[i+1]),
            .out_rem_u (c_rem_u[i+1]),
            .out_rem_v (c_rem_v[i+1]),
            .out_q_u   (c_q_u[i+1]),
            .out_q_v   (c_q_v[i+1]),
            .out_div   (c_div[i+1]),
            .out_tag   (c_tag[i+1])
        );
    end

    assign c_ready[QW] = m_axis_tready;
    assign tag_out     = c_tag[QW];

    // zero vector: texel forced to the corner
    assign texel_x = tag_out.degenerate ? '0 : (cfta_pkg::TEXEL_W)'(c_q_u[QW]);
    assign texel_y = tag_out.degenerate ? '0 : (cfta_pkg::TEXEL_W)'(c_q_v[QW]);

    assign m_axis_tvalid = c_valid[QW];
    assign m_axis_tdata  = {texel_y, texel_x};
    assign m_axis_tuser  = {tag_out.degenerate, tag_out.face};

endmodule

// ----- rtl/cfta_checker.sv -----
module cfta_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic [3:0]  m_axis_tuser
);

    // stalled transfer is held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output transfer changed while stalled");

    // zero vector maps to face 0, texel 0,0
    a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3] |->
            m_axis_tdata == 24'd0 && m_axis_tuser[2:0] == 3'd0)
        else $error("degenerate result with non-zero face or texel");

    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[2:0] <= 3'd5)
        else $error("face out of range");

    // an edge seen in reset leaves the output empty
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

endmodule

bind cube_face_texel_address cfta_checker u_cfta_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/cube_face_texel_address_test.sv -----
`timescale 1ns / 1ps

module cube_face_texel_address_test;

    import cfta_pkg::*;

    localparam int RANDOM_PER_PHASE = 163;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [DIR_W-1:0] z;
        logic [DIR_W-1:0] y;
        logic [DIR_W-1:0] x;
    } direction_t;

    typedef struct packed {
        logic [FACE_W-1:0]  face;
        logic [TEXEL_W-1:0] texel_x;
        logic [TEXEL_W-1:0] texel_y;
        logic               degenerate;
    } texel_hit_t;

    typedef enum int {
        RX_FREE,
        RX_SPARSE,
        RX_COIN,
        RX_BLOCKED
    } rx_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // dir_x, dir_y, dir_z
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // texel_x, texel_y
    logic [OUT_USER_W-1:0] m_axis_tuser;        // face, degenerate

    direction_t  pending_dirs[$];
    texel_hit_t  pending_hits[$];
    logic [FS_W-1:0] face_size_reg = FACE_SIZE_RESET;

    logic     in_fired = 1'b0;
    int       burst_left = 0;
    int       gap_left = 0;
    rx_mode_t rx_mode = RX_FREE;
    int       pattern_left = 0;
    logic [7:0] rx_phase = '0;

    int cycle_count = 0;
    int mismatch_count = 0;
    int unexpected_count = 0;
    int results_seen = 0;
    int degenerate_seen = 0;
    int settings_count = 1;
    int face_hits[6];

    cube_face_texel_address DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic [TEXEL_W-1:0] texel_coord(int c, int m_abs, int s);
        longint num;
        longint q;
        num = longint'(c + m_abs) * longint'(s - 1);
        q = num / (2 * longint'(m_abs));
        if (q > s - 1)
            q = s - 1;
        return q[TEXEL_W-1:0];
    endfunction

    function automatic texel_hit_t locate_texel(direction_t d, logic [FS_W-1:0] fs);
        int x;
        int y;
        int z;
        int ax;
        int ay;
        int az;
        int m;
        int u;
        int v;
        int s;
        axis_t axis;
        texel_hit_t r;
        x = int'($signed(d.x));
        y = int'($signed(d.y));
        z = int'($signed(d.z));
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        s = int'(fs);
        if (s < 1)
            s = 1;
        if (s > MAX_FACE_SIZE_DEF)
            s = MAX_FACE_SIZE_DEF;
        r = '0;
        if (x == 0 && y == 0 && z == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        if (ax >= ay && ax >= az)
            axis = AXIS_X;
        else if (ay >= az)
            axis = AXIS_Y;
        else
            axis = AXIS_Z;
        case (axis)
            AXIS_X:
            begin
                m = x;
                u = (x < 0) ? z : -z;
                v = -y;
            end
            AXIS_Y:
            begin
                m = y;
                u = x;
                v = (y < 0) ? -z : z;
            end
            default:
            begin
                m = z;
                u = (z < 0) ? -x : x;
                v = -y;
            end
        endcase
        r.face = FACE_W'(2 * int'(axis) + ((m < 0) ? 1 : 0));
        r.texel_x = texel_coord(u, (m < 0) ? -m : m, s);
        r.texel_y = texel_coord(v, (m < 0) ? -m : m, s);
        return r;
    endfunction

    function automatic int signed_of(int magnitude, bit neg);
        int val;
        val = neg ? -magnitude : magnitude;
        if (val > 32767)
            val = -32768;
        return val;
    endfunction

    task automatic add_dir(int x, int y, int z);
        direction_t d;
        d.x = DIR_W'(x);
        d.y = DIR_W'(y);
        d.z = DIR_W'(z);
        pending_dirs.push_back(d);
    endtask

    task automatic add_random_direction();
        int pick;
        int major;
        int comp[3];
        int dom;
        direction_t d;
        int extremes[6];
        extremes = '{-32768, -32767, -1, 0, 1, 32767};
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            d = direction_t'({$urandom, $urandom});
            pending_dirs.push_back(d);
        end
        else if (pick < 55)
        begin
            add_dir($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                    $urandom_range(0, 6) - 3);
        end
        else if (pick < 75)
        begin
            // one axis clearly or barely dominant
            major = $urandom_range(1, 32768);
            dom = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
                comp[i] = signed_of($urandom_range(0, major), $urandom_range(0, 1));
            comp[dom] = signed_of(major, $urandom_range(0, 1));
            add_dir(comp[0], comp[1], comp[2]);
        end
        else if (pick < 90)
        begin
            // equal magnitudes on two or three axes
            major = $urandom_range(0, 32768);
            for (int i = 0; i < 3; i++)
                comp[i] = signed_of(major, $urandom_range(0, 1));
            dom = $urandom_range(0, 3);
            if (dom < 3)
                comp[dom] = signed_of($urandom_range(0, major), $urandom_range(0, 1));
            add_dir(comp[0], comp[1], comp[2]);
        end
        else
        begin
            add_dir(extremes[$urandom_range(0, 5)], extremes[$urandom_range(0, 5)],
                    extremes[$urandom_range(0, 5)]);
        end
    endtask

    task automatic apb_write(logic idx, logic [APB_DW-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        face_size_reg = value[FS_W-1:0];
        settings_count++;
    endtask

    task automatic wait_idle();
        while (pending_dirs.size() != 0 || s_axis_tvalid || pending_hits.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // sender: bursts of transfers with random gaps, valid held until taken
    always @(negedge clk)
    begin : sender
        direction_t nxt;
        if (s_axis_tvalid && !in_fired)
        begin
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
        end
        else if (pending_dirs.size() != 0)
        begin
            nxt = pending_dirs.pop_front();
            s_axis_tdata <= nxt;
            s_axis_tvalid <= 1'b1;
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : receiver
        if (pattern_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            pattern_left = $urandom_range(20, 200);
        end
        else
        begin
            pattern_left--;
        end
        rx_phase = rx_phase + 8'd1;
        case (rx_mode)
            RX_FREE:    m_axis_tready <= 1'b1;
            RX_SPARSE:  m_axis_tready <= (rx_phase[1:0] != 2'b11);
            RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
            default:    m_axis_tready <= (rx_phase[4:0] < 5'd12);
        endcase
    end

    always @(posedge clk)
    begin : monitor
        texel_hit_t got;
        texel_hit_t want;
        in_fired <= s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.face = m_axis_tuser[FACE_W-1:0];
            got.degenerate = m_axis_tuser[FACE_W];
            got.texel_x = m_axis_tdata[TEXEL_W-1:0];
            got.texel_y = m_axis_tdata[2*TEXEL_W-1:TEXEL_W];
            if (pending_hits.size() == 0)
            begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10)
                    $display("unexpected transfer: face %0d x %0d y %0d degenerate %0b",
                             got.face, got.texel_x, got.texel_y, got.degenerate);
            end
            else
            begin
                want = pending_hits.pop_front();
                results_seen++;
                if (want.face < 6)
                    face_hits[want.face]++;
                if (want.degenerate)
                    degenerate_seen++;
                if (got.face !== want.face || got.texel_x !== want.texel_x ||
                    got.texel_y !== want.texel_y || got.degenerate !== want.degenerate)
                begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= 10)
                        $display({"mismatch: expected face %0d x %0d y %0d degenerate %0b,",
                                  " got face %0d x %0d y %0d degenerate %0b"},
                                 want.face, want.texel_x, want.texel_y, want.degenerate,
                                 got.face, got.texel_x, got.texel_y, got.degenerate);
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
            pending_hits.push_back(locate_texel(direction_t'(s_axis_tdata), face_size_reg));
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** cube_face_texel_address: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        int sizes[9];
        sizes = '{4096, 1, 0, 8191, 2, 4097, 3, 0, 256};
        sizes[7] = $urandom_range(4, 4095);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first phase runs at the reset face size
        add_dir(0, 0, 0);
        add_dir(32767, 0, 0);
        add_dir(-32768, 0, 0);
        add_dir(0, 32767, 0);
        add_dir(0, -32768, 0);
        add_dir(0, 0, 32767);
        add_dir(0, 0, -32768);
        add_dir(100, 100, 100);
        add_dir(0, -5, 5);
        add_dir(-7, 7, -7);
        add_dir(-32768, -32768, -32768);
        add_dir(32767, -32768, 32767);
        add_dir(-32768, 32767, -32768);
        add_dir(1, 0, 0);
        add_dir(0, 0, -1);
        add_dir(0, 1, 0);
        add_dir(16384, -16384, 16383);
        add_dir(-16384, 16384, -16384);
        add_dir(32767, 32767, -32768);
        add_dir(1000, -999, 999);
        add_dir(-999, 1000, -1000);
        add_dir(300, -301, -300);
        add_dir(-1, -1, 0);
        add_dir(32767, 32767, 32767);
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            add_random_direction();
        wait_idle();

        for (int p = 0; p < 9; p++)
        begin
            apb_write(REG_FACE_SIZE, APB_DW'(sizes[p]));
            if (sizes[p] == 4096 || sizes[p] == 1)
            begin
                add_dir(0, 0, 0);
                add_dir(-32768, 32767, -32768);
                add_dir(32767, -32768, 32767);
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                add_random_direction();
            wait_idle();
        end

        $display("covered %0d directions over %0d face sizes, %0d zero vectors",
                 results_seen, settings_count, degenerate_seen);
        $display("faces +x %0d -x %0d +y %0d -y %0d +z %0d -z %0d",
                 face_hits[0], face_hits[1], face_hits[2], face_hits[3],
                 face_hits[4], face_hits[5]);
        if (mismatch_count == 0 && unexpected_count == 0)
            $display("** cube_face_texel_address: PASSED **");
        else
            $display("** cube_face_texel_address: FAILED **");
        $finish;
    end

endmodule
